// ===== sv/dqsf_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the deque
package dqsf_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_COUNT_EVEN = 3'd4,
        REQ_SEARCH     = 3'd5,
        REQ_FILTER     = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic finish;
    } dqsf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic empty;
        logic walk_req;
        logic walk_done;
    } dqsf_stat_t;

endpackage

// ===== sv/dqsf_ctrl.sv =====
// request sequencer: accept, execute, walk the entries, emit final beat
module dqsf_ctrl
    import dqsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dqsf_stat_t stat,
    output dqsf_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.out_free) begin
                    state_next = (stat.walk_req && !stat.empty) ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (stat.out_free && stat.walk_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/dqsf_datapath.sv =====
// ring buffer storage, pointers, scan accumulators and result register
module dqsf_datapath
    import dqsf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dqsf_cmd_t                cmd,
    output dqsf_stat_t               stat,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic                     m_found,
    output logic [CNT_W-1:0]         m_even_count,
    output logic signed [DATA_W-1:0] m_data,
    output logic                     m_data_valid,
    output logic                     m_last
);

    // remainder mod 3 of an unsigned word, via nibble digit sums (16 == 1 mod 3)
    function automatic logic [1:0] mod3_u32(input logic [DATA_W-1:0] v);
        logic [6:0] s1;
        logic [4:0] s2;
        logic [4:0] s3;
        logic [1:0] r;
        s1 = '0;
        for (int k = 0; k < DATA_W / 4; k++) begin
            s1 = s1 + 7'(v[4*k +: 4]);
        end
        s2 = 5'(s1[3:0]) + 5'(s1[6:4]);
        s3 = 5'(s2[3:0]) + 5'(s2[4]);
        case (s3)
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  r = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: r = 2'd1;
            default:                               r = 2'd2;
        endcase
        return r;
    endfunction

    // ring slot of base plus offset
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    logic [REQ_W-1:0]         req_reg, req_next;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic [DATA_W-1:0]        rd_data_reg;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     rd_last_reg, rd_last_next;
    logic [CNT_W-1:0]         evens_reg, evens_next;
    logic                     hit_reg, hit_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [DATA_W-1:0]        pend_data_reg, pend_data_next;

    logic                     m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]        m_status_reg, m_status_next;
    logic                     m_found_reg, m_found_next;
    logic [CNT_W-1:0]         m_evens_reg, m_evens_next;
    logic [DATA_W-1:0]        m_data_reg, m_data_next;
    logic                     m_dv_reg, m_dv_next;
    logic                     m_last_reg, m_last_next;

    logic                     out_free;
    logic                     out_load;
    logic                     empty;
    logic                     full;
    logic                     mem_we;
    logic [IDX_W-1:0]         wr_addr;
    logic                     mem_re;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         head_dec;
    logic [IDX_W-1:0]         head_inc;
    logic                     match;

    assign out_free = !m_valid_reg || m_ready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= CNT_W'(DEPTH));
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rd_addr  = slot_add(head_reg, issue_reg[IDX_W-1:0]);
    assign match    = !rd_data_reg[DATA_W-1] && (mod3_u32(rd_data_reg) == 2'd1);

    assign stat.out_free  = out_free;
    assign stat.empty     = empty;
    assign stat.walk_req  = req_reg inside {REQ_COUNT_EVEN, REQ_SEARCH, REQ_FILTER};
    assign stat.walk_done = rd_vld_reg && rd_last_reg;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found      = m_found_reg;
    assign m_even_count = m_evens_reg;
    assign m_data       = m_data_reg;
    assign m_data_valid = m_dv_reg;
    assign m_last       = m_last_reg;

    always_comb begin
        req_next       = req_reg;
        value_next     = value_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_vld_next    = rd_vld_reg;
        rd_last_next   = rd_last_reg;
        evens_next     = evens_reg;
        hit_next       = hit_reg;
        pend_vld_next  = pend_vld_reg;
        pend_data_next = pend_data_reg;
        m_status_next  = m_status_reg;
        m_found_next   = m_found_reg;
        m_evens_next   = m_evens_reg;
        m_data_next    = m_data_reg;
        m_dv_next      = m_dv_reg;
        m_last_next    = m_last_reg;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = slot_add(head_reg, count_reg[IDX_W-1:0]);
        mem_re         = 1'b0;

        if (cmd.load) begin
            req_next   = s_req_type;
            value_next = s_value;
        end

        if (cmd.exec && out_free) begin
            issue_next    = '0;
            rd_vld_next   = 1'b0;
            evens_next    = '0;
            hit_next      = 1'b0;
            pend_vld_next = 1'b0;
            out_load      = 1'b0;
            m_status_next = STAT_OK;
            m_found_next  = 1'b0;
            m_evens_next  = '0;
            m_data_next   = '0;
            m_dv_next     = 1'b0;
            m_last_next   = 1'b1;
            case (req_reg)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    out_load = 1'b1;
                    if (full) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (req_reg == REQ_PUSH_FRONT) begin
                            wr_addr   = head_dec;
                            head_next = head_dec;
                        end
                    end
                end
                REQ_POP_BACK, REQ_POP_FRONT: begin
                    out_load = 1'b1;
                    if (empty) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        count_next = count_reg - 1'b1;
                        if (req_reg == REQ_POP_FRONT) begin
                            head_next = head_inc;
                        end
                    end
                end
                REQ_COUNT_EVEN: begin
                    out_load = empty;
                end
                REQ_SEARCH, REQ_FILTER: begin
                    out_load = empty;
                    m_status_next = STAT_EMPTY;
                end
                default: begin
                    out_load = 1'b1;
                end
            endcase
        end

        if (cmd.walk && out_free) begin
            // read issue stage
            if (issue_reg < count_reg) begin
                mem_re       = 1'b1;
                issue_next   = issue_reg + 1'b1;
                rd_vld_next  = 1'b1;
                rd_last_next = (CNT_W'(issue_reg + 1'b1) == count_reg);
            end else begin
                rd_vld_next  = 1'b0;
            end
            // evaluate stage
            if (rd_vld_reg) begin
                evens_next = evens_reg + (rd_data_reg[0] ? CNT_W'(0) : CNT_W'(1));
                if (rd_data_reg == value_reg) begin
                    hit_next = 1'b1;
                end
                if (req_reg == REQ_FILTER && match) begin
                    // a newer match shows the held one is not the final beat
                    if (pend_vld_reg) begin
                        out_load      = 1'b1;
                        m_status_next = STAT_OK;
                        m_found_next  = 1'b0;
                        m_evens_next  = '0;
                        m_data_next   = pend_data_reg;
                        m_dv_next     = 1'b1;
                        m_last_next   = 1'b0;
                    end
                    pend_vld_next  = 1'b1;
                    pend_data_next = rd_data_reg;
                end
            end
        end

        if (cmd.finish && out_free) begin
            out_load      = 1'b1;
            m_status_next = STAT_OK;
            m_found_next  = 1'b0;
            m_evens_next  = '0;
            m_data_next   = '0;
            m_dv_next     = 1'b0;
            m_last_next   = 1'b1;
            case (req_reg)
                REQ_COUNT_EVEN: m_evens_next = evens_reg;
                REQ_SEARCH:     m_found_next = hit_reg;
                REQ_FILTER: begin
                    m_data_next = pend_vld_reg ? pend_data_reg : '0;
                    m_dv_next   = pend_vld_reg;
                end
                default: begin
                    m_found_next = 1'b0;
                end
            endcase
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= value_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            rd_last_reg  <= rd_last_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        value_reg     <= value_next;
        evens_reg     <= evens_next;
        hit_reg       <= hit_next;
        pend_data_reg <= pend_data_next;
        m_status_reg  <= m_status_next;
        m_found_reg   <= m_found_next;
        m_evens_reg   <= m_evens_next;
        m_data_reg    <= m_data_next;
        m_dv_reg      <= m_dv_next;
        m_last_reg    <= m_last_next;
    end

endmodule

// ===== sv/deque_with_search_and_filter.sv =====
// top level: bounded deque with even count, search and mod-3 filter scan
// push, pop and undefined requests are answered from the execute state, which loads their beat
// count, search and filter walk a non-empty ring one entry per cycle while the output register
//   is free, through the registered memory read port
// requests: one at a time; a new request is taken once the previous final beat is loaded,
//   while that beat may still wait in the output register
// reset: synchronous active-low aresetn empties the queue; storage contents are not cleared
module deque_with_search_and_filter
    import dqsf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic signed [DATA_W-1:0] s_value,
    // result channel, one or more beats per request, m_last on the final one
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic                     m_found,
    output logic [CNT_W-1:0]         m_even_count,
    output logic signed [DATA_W-1:0] m_data,
    output logic                     m_data_valid,
    output logic                     m_last
);

    // command and status between sequencer and datapath
    dqsf_cmd_t  cmd;
    dqsf_stat_t stat;

    // sequencer: idle, execute, walk, finish
    dqsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // ring buffer, pointers, scan state and the output register
    dqsf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_even_count (m_even_count),
        .m_data       (m_data),
        .m_data_valid (m_data_valid),
        .m_last       (m_last)
    );

endmodule

// ===== tb/sv/deque_with_search_and_filter_tb.sv =====
// self-checking testbench for the deque with even count, search and mod-3 filter
`timescale 1ns / 1ps

module deque_with_search_and_filter_tb
    import dqsf_pkg::*;
;

    // request code outside the defined set, answered with a plain ok beat
    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 3'd7;
    localparam int PHASE_ITEMS = 46;
    localparam int DRAIN_CYCLES = 80;

    // one result beat as seen on the m_ side
    typedef struct {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [CNT_W-1:0]  even_count;
        logic [DATA_W-1:0] data;
        logic              data_valid;
        logic              last;
    } beat_t;

    // shadow copy of the deque: predicts the beats of every accepted request
    // and checks the beats that come back, oldest first
    class deque_shadow;
        logic [DATA_W-1:0] slots [DEPTH];
        logic [IDX_W-1:0]  head;
        logic [CNT_W-1:0]  fill;
        beat_t             pending_beats [$];
        int                errors;
        int                requests;
        int                beats_seen;
        int                full_drops;
        int                empty_replies;
        int                filter_hits;
        int                deepest;

        function new();
            head = '0;
            fill = '0;
        endfunction

        function void take_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] value);
            beat_t             b;
            logic [IDX_W-1:0]  idx;
            logic [DATA_W-1:0] e;
            logic [CNT_W-1:0]  evens;
            int                hits;
            b = '{status: STAT_OK, found: 1'b0, even_count: '0, data: '0,
                  data_valid: 1'b0, last: 1'b1};
            requests++;
            case (req)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    if (fill == DEPTH) begin
                        b.status = STAT_FULL;
                        full_drops++;
                    end else begin
                        if (req == REQ_PUSH_BACK) begin
                            idx = head + fill[IDX_W-1:0];
                            slots[idx] = value;
                        end else begin
                            head = head - 1'b1;
                            slots[head] = value;
                        end
                        fill++;
                        if (fill > deepest) deepest = int'(fill);
                    end
                    pending_beats.push_back(b);
                end
                REQ_POP_BACK, REQ_POP_FRONT: begin
                    if (fill == 0) begin
                        b.status = STAT_EMPTY;
                    end else begin
                        if (req == REQ_POP_FRONT) head = head + 1'b1;
                        fill--;
                    end
                    pending_beats.push_back(b);
                end
                REQ_COUNT_EVEN: begin
                    evens = '0;
                    for (int i = 0; i < fill; i++) begin
                        idx = head + i[IDX_W-1:0];
                        if (!slots[idx][0]) evens++;
                    end
                    b.even_count = evens;
                    pending_beats.push_back(b);
                end
                REQ_SEARCH: begin
                    if (fill == 0) begin
                        b.status = STAT_EMPTY;
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            idx = head + i[IDX_W-1:0];
                            if (slots[idx] == value) b.found = 1'b1;
                        end
                    end
                    pending_beats.push_back(b);
                end
                REQ_FILTER: begin
                    if (fill == 0) begin
                        b.status = STAT_EMPTY;
                        pending_beats.push_back(b);
                    end else begin
                        hits = 0;
                        for (int i = 0; i < fill; i++) begin
                            idx = head + i[IDX_W-1:0];
                            e = slots[idx];
                            // unsigned remainder: negative values are kept out by their sign bit
                            if (!e[DATA_W-1] && (e % 3) == 1) begin
                                b.data = e;
                                b.data_valid = 1'b1;
                                b.last = 1'b0;
                                pending_beats.push_back(b);
                                hits++;
                            end
                        end
                        if (hits == 0) begin
                            pending_beats.push_back(b);
                        end else begin
                            pending_beats[$].last = 1'b1;
                            filter_hits += hits;
                        end
                    end
                end
                default: pending_beats.push_back(b);
            endcase
            if (pending_beats[$].status == STAT_EMPTY) empty_replies++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                          beats_seen, name, got, want));
        endtask

        task check_beat(beat_t got);
            beat_t want;
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                          beats_seen));
            end else begin
                want = pending_beats.pop_front();
                check_field("status", DATA_W'(got.status), DATA_W'(want.status));
                check_field("found", DATA_W'(got.found), DATA_W'(want.found));
                check_field("even_count", DATA_W'(got.even_count),
                            DATA_W'(want.even_count));
                check_field("data", got.data, want.data);
                check_field("data_valid", DATA_W'(got.data_valid),
                            DATA_W'(want.data_valid));
                check_field("last", DATA_W'(got.last), DATA_W'(want.last));
            end
            beats_seen++;
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [REQ_W-1:0]         s_req_type = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic                     m_found;
    logic [CNT_W-1:0]         m_even_count;
    logic signed [DATA_W-1:0] m_data;
    logic                     m_data_valid;
    logic                     m_last;

    deque_shadow sb = new();

    // idle odds in percent, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // random traffic alternates between filling the ring and draining it
    bit growing = 1'b1;

    always #4 aclk = ~aclk;

    deque_with_search_and_filter u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_even_count (m_even_count),
        .m_data       (m_data),
        .m_data_valid (m_data_valid),
        .m_last       (m_last)
    );

    // receiver: random backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: every beat taken is checked against the oldest prediction
    always @(posedge aclk) begin
        beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status     = m_status;
            got.found      = m_found;
            got.even_count = m_even_count;
            got.data       = m_data;
            got.data_valid = m_data_valid;
            got.last       = m_last;
            sb.check_beat(got);
        end
    end

    // one request beat: optional idle cycles, then hold valid until s_ready
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_request(req, value);
    endtask

    // sender goes quiet until every predicted beat has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
    endtask

    // value mix: full-range random, small values for mod-3 and parity, extremes
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        logic [DATA_W-1:0] v;
        roll = $urandom_range(99);
        if (roll < 40) begin
            v = $urandom;
        end else if (roll < 70) begin
            v = $urandom_range(30);
        end else if (roll < 85) begin
            v = -$urandom_range(30, 1);
        end else begin
            case ($urandom_range(4))
                0:       v = 32'h7fff_ffff;
                1:       v = 32'h8000_0000;
                2:       v = 32'hffff_ffff;
                3:       v = 32'h0000_0001;
                default: v = 32'h0000_0000;
            endcase
        end
        return v;
    endfunction

    // queries: even count, search (often for a stored value), filter, odd undefined code
    task automatic random_query();
        int roll;
        logic [IDX_W-1:0] idx;
        roll = $urandom_range(99);
        if (roll < 30) begin
            send_req(REQ_COUNT_EVEN, pick_value());
        end else if (roll < 65) begin
            if (sb.fill != 0 && $urandom_range(1)) begin
                idx = sb.head + IDX_W'($urandom_range(sb.fill - 1));
                send_req(REQ_SEARCH, sb.slots[idx]);
            end else begin
                send_req(REQ_SEARCH, pick_value());
            end
        end else if (roll < 93) begin
            send_req(REQ_FILTER, pick_value());
        end else begin
            send_req(REQ_UNDEFINED, pick_value());
        end
    endtask

    task automatic random_request();
        int roll;
        roll = $urandom_range(99);
        // flip direction at the ends, after a few drops on a full ring
        if (growing && sb.fill == DEPTH && roll < 30) growing = 1'b0;
        if (!growing && sb.fill == 0 && roll < 40) growing = 1'b1;
        roll = $urandom_range(99);
        if (growing) begin
            if (roll < 70)      send_req(roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
            else if (roll < 75) send_req(roll[0] ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
            else                random_query();
        end else begin
            if (roll < 65)      send_req(roll[0] ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
            else if (roll < 70) send_req(roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
            else                random_query();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-queue answers and the undefined code
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_POP_FRONT, 32'hffff_ffff);
        send_req(REQ_SEARCH, 32'h0);
        send_req(REQ_FILTER, 32'h0);
        send_req(REQ_COUNT_EVEN, 32'h0);
        send_req(REQ_UNDEFINED, 32'hffff_ffff);
        // extremes at both ends; the front push wraps the head below slot zero
        send_req(REQ_PUSH_BACK, 32'h7fff_ffff);
        send_req(REQ_PUSH_FRONT, 32'h8000_0000);
        send_req(REQ_PUSH_BACK, 32'h0);
        send_req(REQ_PUSH_FRONT, 32'd3);
        send_req(REQ_FILTER, 32'h0);
        send_req(REQ_COUNT_EVEN, 32'h0);
        send_req(REQ_SEARCH, 32'h8000_0000);
        send_req(REQ_SEARCH, 32'd5);
        send_req(REQ_PUSH_BACK, -32'sd2);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
        // negative value with remainder -2 and a multiple of three: filter finds nothing
        send_req(REQ_PUSH_BACK, -32'sd5);
        send_req(REQ_PUSH_FRONT, 32'd6);
        send_req(REQ_FILTER, 32'h0);
        send_req(REQ_UNDEFINED, 32'h5555_5555);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_FRONT, 32'h0);

        // random phases: no idling, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests and %0d result beats, ring filled to %0d",
                 sb.requests, sb.beats_seen, sb.deepest);
        $display("full drops %0d, empty replies %0d, filter matches %0d, mismatches %0d",
                 sb.full_drops, sb.empty_replies, sb.filter_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("[deque_with_search_and_filter] OK");
        end else begin
            $display("[deque_with_search_and_filter] ERROR");
        end
        $finish;
    end

    // watchdog: a hang or a missing beat ends here
    initial begin
        #5_000_000;
        $display("timeout with %0d beats still expected", sb.pending_beats.size());
        $display("[deque_with_search_and_filter] ERROR");
        $finish;
    end

endmodule
